[sv/plob_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package plob_pkg;
	localparam int LEVELS = 64;
	localparam int IDX_W = $clog2(LEVELS);
	localparam int CNT_W = $clog2(LEVELS + 1);
	localparam int PRICE_W = 32;
	localparam int QTY_W = 48;
	localparam int ENTRY_W = PRICE_W + QTY_W;

	localparam logic FUNC_SNAPSHOT = 1'b0;
	localparam logic FUNC_UPDATE = 1'b1;
	localparam logic SIDE_BUY = 1'b0;
	localparam logic SIDE_SELL = 1'b1;

	typedef struct packed {
		logic func;
		logic side;
		logic [PRICE_W-1:0] price;
		logic [QTY_W-1:0] quantity;
	} plob_in_t;

	typedef struct packed {
		logic [PRICE_W-1:0] bid_top;
		logic [PRICE_W-1:0] ask_top;
		logic [PRICE_W:0] mid_twice;
		logic both_present;
		logic dropped;
	} plob_out_t;
endpackage
`default_nettype wire

[sv/price_level_order_book.sv]
`timescale 1ns / 1ps
// channel  | ports                    | handshake
// command  | start, busy, cmd         | taken when start && !busy
// result   | result_valid, result     | one-cycle strobe, no back pressure
// Each item scans all stored levels of both tables: the bid and ask memories are
// read one address per cycle, and busy stays high from acceptance until the result is formed.
// The result strobe is high in the first cycle with busy low, in which the next item may
// already be taken, so a new item can follow as soon as the last result is shown.
// The scan finds the matching price, the lowest free entry and both best prices at once;
// the best prices are then corrected for the single entry that the item changes.
// Reset clears the used bits (flip-flops); memory contents need no clearing.
`default_nettype none
module price_level_order_book (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire plob_pkg::plob_in_t cmd,
	output logic result_valid,
	output plob_pkg::plob_out_t result
);
	import plob_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0] state_q;
	logic [CNT_W-1:0] addr_q;
	logic rd_vld_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	plob_in_t cmd_q;
	logic [LEVELS-1:0] bid_used_q, ask_used_q;
	logic hit_q, free_q;
	logic [IDX_W-1:0] hit_idx_q, free_idx_q;
	logic [PRICE_W-1:0] bb_q, ba_q, bb2_q, ba2_q;
	logic bb_any_q, ba_any_q, bb2_any_q, ba2_any_q;
	logic [ENTRY_W-1:0] bid_rd, ask_rd;
	logic we_bid, we_ask;
	logic [IDX_W-1:0] waddr;
	logic [PRICE_W-1:0] bp, ap;
	logic own_used, own_match, remove;
	logic [PRICE_W-1:0] own_p;
	logic [LEVELS-1:0] own_used_v;

	// final-cycle decision
	logic do_write, do_drop, do_remove;
	logic [IDX_W-1:0] tgt;
	logic [PRICE_W-1:0] fb_bid, fb_ask;

	assign busy = (state_q != ST_IDLE);
	assign bp = bid_rd[ENTRY_W-1:QTY_W];
	assign ap = ask_rd[ENTRY_W-1:QTY_W];
	assign remove = (cmd_q.func == FUNC_UPDATE) && (cmd_q.quantity == '0);
	assign own_used_v = (cmd_q.side == SIDE_SELL) ? ask_used_q : bid_used_q;
	assign own_used = own_used_v[rd_idx_s1];
	assign own_p = (cmd_q.side == SIDE_SELL) ? ap : bp;
	assign own_match = rd_vld_s1 && own_used && (own_p == cmd_q.price);

	assign do_remove = hit_q && remove;
	assign do_write = hit_q ? !remove : (!remove && free_q);
	assign do_drop = !hit_q && !remove && !free_q;
	assign tgt = hit_q ? hit_idx_q : free_idx_q;
	assign waddr = tgt;
	assign we_bid = (state_q == ST_DONE) && do_write && (cmd_q.side == SIDE_BUY);
	assign we_ask = (state_q == ST_DONE) && do_write && (cmd_q.side == SIDE_SELL);

	plob_ram #(.WIDTH(ENTRY_W), .DEPTH(LEVELS)) u_bid (
		.clk(clk), .we(we_bid), .waddr(waddr), .wdata({cmd_q.price, cmd_q.quantity}),
		.raddr(addr_q[IDX_W-1:0]), .rdata(bid_rd)
	);
	plob_ram #(.WIDTH(ENTRY_W), .DEPTH(LEVELS)) u_ask (
		.clk(clk), .we(we_ask), .waddr(waddr), .wdata({cmd_q.price, cmd_q.quantity}),
		.raddr(addr_q[IDX_W-1:0]), .rdata(ask_rd)
	);

	// best prices after the change: bb/ba over all, bb2/ba2 excluding the hit entry
	always_comb begin
		fb_bid = bb_q;
		fb_ask = ba_q;
		if (cmd_q.side == SIDE_BUY) begin
			if (do_remove) begin
				fb_bid = bb2_any_q ? bb2_q : '0;
			end else if (do_write) begin
				if (hit_q) begin
					fb_bid = (!bb2_any_q || cmd_q.price > bb2_q) ? cmd_q.price : bb2_q;
				end else begin
					fb_bid = (!bb_any_q || cmd_q.price > bb_q) ? cmd_q.price : bb_q;
				end
			end else begin
				fb_bid = bb_any_q ? bb_q : '0;
			end
			fb_ask = ba_any_q ? ba_q : '0;
		end else begin
			if (do_remove) begin
				fb_ask = ba2_any_q ? ba2_q : '0;
			end else if (do_write) begin
				if (hit_q) begin
					fb_ask = (!ba2_any_q || cmd_q.price < ba2_q) ? cmd_q.price : ba2_q;
				end else begin
					fb_ask = (!ba_any_q || cmd_q.price < ba_q) ? cmd_q.price : ba_q;
				end
			end else begin
				fb_ask = ba_any_q ? ba_q : '0;
			end
			fb_bid = bb_any_q ? bb_q : '0;
		end
	end

	// sequencer: scan addresses, collect, finish
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			addr_q <= '0;
			rd_vld_s1 <= 1'b0;
			result_valid <= 1'b0;
			bid_used_q <= '0;
			ask_used_q <= '0;
		end else begin
			result_valid <= 1'b0;
			rd_vld_s1 <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_SCAN;
						addr_q <= '0;
					end
				end
				ST_SCAN: begin
					if (addr_q < CNT_W'(LEVELS)) begin
						rd_vld_s1 <= 1'b1;
						addr_q <= addr_q + 1'b1;
					end else if (!rd_vld_s1) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
					result_valid <= 1'b1;
					if (cmd_q.side == SIDE_BUY) begin
						if (do_write) bid_used_q[tgt] <= 1'b1;
						if (do_remove) bid_used_q[tgt] <= 1'b0;
					end else begin
						if (do_write) ask_used_q[tgt] <= 1'b1;
						if (do_remove) ask_used_q[tgt] <= 1'b0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// scan accumulators (payload, cleared at acceptance)
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			cmd_q <= cmd;
			hit_q <= 1'b0;
			free_q <= 1'b0;
			hit_idx_q <= '0;
			free_idx_q <= '0;
			bb_any_q <= 1'b0;
			ba_any_q <= 1'b0;
			bb2_any_q <= 1'b0;
			ba2_any_q <= 1'b0;
			bb_q <= '0;
			ba_q <= '0;
			bb2_q <= '0;
			ba2_q <= '0;
		end
		if (rd_vld_s1) begin
			if (own_match && !hit_q) begin
				hit_q <= 1'b1;
				hit_idx_q <= rd_idx_s1;
			end
			if (!own_used && !free_q) begin
				free_q <= 1'b1;
				free_idx_q <= rd_idx_s1;
			end
			if (bid_used_q[rd_idx_s1]) begin
				if (!bb_any_q || bp > bb_q) begin
					bb_q <= bp;
					bb_any_q <= 1'b1;
				end
				if (!(cmd_q.side == SIDE_BUY && own_match) && (!bb2_any_q || bp > bb2_q)) begin
					bb2_q <= bp;
					bb2_any_q <= 1'b1;
				end
			end
			if (ask_used_q[rd_idx_s1]) begin
				if (!ba_any_q || ap < ba_q) begin
					ba_q <= ap;
					ba_any_q <= 1'b1;
				end
				if (!(cmd_q.side == SIDE_SELL && own_match) && (!ba2_any_q || ap < ba2_q)) begin
					ba2_q <= ap;
					ba2_any_q <= 1'b1;
				end
			end
		end
		if (state_q == ST_SCAN && addr_q < CNT_W'(LEVELS)) begin
			rd_idx_s1 <= addr_q[IDX_W-1:0];
		end
		if (state_q == ST_DONE) begin
			result.bid_top <= fb_bid;
			result.ask_top <= fb_ask;
			result.mid_twice <= {1'b0, fb_bid} + {1'b0, fb_ask};
			result.both_present <= (fb_bid != '0) && (fb_ask != '0);
			result.dropped <= do_drop;
		end
	end

	a_strobe_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |=> result_valid) else $error("missing result strobe");
	a_busy_during_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy)) else $error("result without item");
	a_no_write_and_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> !(do_write && do_drop)) else $error("write on drop");
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		addr_q <= CNT_W'(LEVELS)) else $error("scan address overrun");
endmodule
`default_nettype wire

[sv/plob_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module plob_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[tb/price_level_order_book_test.sv]
`timescale 1ns / 1ps
module price_level_order_book_test;
	import plob_pkg::*;

	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 200;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	plob_in_t cmd;
	logic result_valid;
	plob_out_t result;

	price_level_order_book DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.result_valid(result_valid),
		.result(result)
	);

	// book mirror
	logic [PRICE_W-1:0] bid_px [LEVELS];
	logic [QTY_W-1:0] bid_qty [LEVELS];
	logic bid_used [LEVELS];
	logic [PRICE_W-1:0] ask_px [LEVELS];
	logic [QTY_W-1:0] ask_qty [LEVELS];
	logic ask_used [LEVELS];

	plob_in_t pending_items[$];
	plob_out_t expected_quotes[$];
	int errors;
	int idle_cycles;
	int gap_left;
	bit stim_done;
	bit took_q;

	// price pool so that updates and removes hit stored levels
	logic [PRICE_W-1:0] price_pool[$];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int rand_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 80);
	endfunction

	// apply one event to the mirror and form its quote
	function automatic plob_out_t book_apply(plob_in_t it);
		plob_out_t q;
		int hit;
		int free_i;
		logic [PRICE_W-1:0] bb;
		logic [PRICE_W-1:0] ba;
		bit any;
		bit remove;
		hit = -1;
		free_i = -1;
		remove = (it.func == FUNC_UPDATE) && (it.quantity == '0);
		q = '0;
		for (int i = 0; i < LEVELS; i++) begin
			if (it.side == SIDE_SELL) begin
				if (hit < 0 && ask_used[i] && ask_px[i] == it.price) hit = i;
				if (!ask_used[i] && free_i < 0) free_i = i;
			end else begin
				if (hit < 0 && bid_used[i] && bid_px[i] == it.price) hit = i;
				if (!bid_used[i] && free_i < 0) free_i = i;
			end
		end
		if (hit >= 0) begin
			if (it.side == SIDE_SELL) begin
				if (remove) ask_used[hit] = 1'b0;
				else ask_qty[hit] = it.quantity;
			end else begin
				if (remove) bid_used[hit] = 1'b0;
				else bid_qty[hit] = it.quantity;
			end
		end else if (!remove) begin
			if (free_i < 0) begin
				q.dropped = 1'b1;
			end else if (it.side == SIDE_SELL) begin
				ask_px[free_i] = it.price;
				ask_qty[free_i] = it.quantity;
				ask_used[free_i] = 1'b1;
			end else begin
				bid_px[free_i] = it.price;
				bid_qty[free_i] = it.quantity;
				bid_used[free_i] = 1'b1;
			end
		end
		bb = '0;
		any = 0;
		for (int i = 0; i < LEVELS; i++)
			if (bid_used[i] && (!any || bid_px[i] > bb)) begin
				bb = bid_px[i];
				any = 1;
			end
		ba = '0;
		any = 0;
		for (int i = 0; i < LEVELS; i++)
			if (ask_used[i] && (!any || ask_px[i] < ba)) begin
				ba = ask_px[i];
				any = 1;
			end
		q.bid_top = bb;
		q.ask_top = ba;
		q.mid_twice = {1'b0, bb} + {1'b0, ba};
		q.both_present = (bb != 0) && (ba != 0);
		return q;
	endfunction

	function automatic plob_in_t make_item(logic f, logic s, logic [PRICE_W-1:0] p,
			logic [QTY_W-1:0] qt);
		plob_in_t it;
		it.func = f;
		it.side = s;
		it.price = p;
		it.quantity = qt;
		return it;
	endfunction

	function automatic logic [QTY_W-1:0] rand_qty();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return '0;
		if (r == 1) return '1;
		return QTY_W'({$urandom, $urandom});
	endfunction

	// random event, mostly on a small set of prices
	function automatic plob_in_t rand_item();
		logic [PRICE_W-1:0] p;
		int r;
		r = $urandom_range(0, 99);
		if (r < 70 && price_pool.size() > 0)
			p = price_pool[$urandom_range(0, price_pool.size() - 1)];
		else if (r < 75)
			p = (r == 70) ? '0 : '1;
		else
			p = $urandom;
		if (price_pool.size() < 90 && $urandom_range(0, 3) == 0) price_pool.push_back(p);
		return make_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), p, rand_qty());
	endfunction

	// stimulus
	initial begin
		errors = 0;
		stim_done = 0;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		for (int i = 0; i < LEVELS; i++) begin
			bid_used[i] = 0;
			ask_used[i] = 0;
			bid_px[i] = '0;
			ask_px[i] = '0;
			bid_qty[i] = '0;
			ask_qty[i] = '0;
		end
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, zero-qty snapshot, price zero, removes, absent remove
		pending_items.push_back(make_item(FUNC_SNAPSHOT, SIDE_BUY, '0, '1));
		pending_items.push_back(make_item(FUNC_SNAPSHOT, SIDE_SELL, '1, '0));
		pending_items.push_back(make_item(FUNC_SNAPSHOT, SIDE_BUY, 32'd100, '0));
		pending_items.push_back(make_item(FUNC_UPDATE, SIDE_SELL, 32'd105, 48'd7));
		pending_items.push_back(make_item(FUNC_UPDATE, SIDE_SELL, 32'd105, 48'd9));
		pending_items.push_back(make_item(FUNC_UPDATE, SIDE_BUY, 32'd100, '0));
		pending_items.push_back(make_item(FUNC_UPDATE, SIDE_BUY, 32'd555, '0));
		pending_items.push_back(make_item(FUNC_UPDATE, SIDE_BUY, '1, '1));
		pending_items.push_back(make_item(FUNC_UPDATE, SIDE_SELL, '1, '0));
		pending_items.push_back(make_item(FUNC_SNAPSHOT, SIDE_SELL, '0, 48'd1));
		pending_items.push_back(make_item(FUNC_UPDATE, SIDE_SELL, '0, '0));
		pending_items.push_back(make_item(FUNC_UPDATE, SIDE_BUY, '0, '0));
		pending_items.push_back(make_item(FUNC_UPDATE, SIDE_BUY, '1, '0));
		// fill both sides past capacity to reach the full-side drop
		for (int i = 0; i < LEVELS + 2; i++) begin
			pending_items.push_back(make_item(FUNC_SNAPSHOT, SIDE_BUY, 32'd1000 + i, 48'd1));
			pending_items.push_back(make_item(FUNC_UPDATE, SIDE_SELL, 32'd2000 + i, 48'd1));
		end
		// overwrite in place and remove while full
		pending_items.push_back(make_item(FUNC_UPDATE, SIDE_BUY, 32'd1005, 48'd3));
		pending_items.push_back(make_item(FUNC_UPDATE, SIDE_BUY, 32'd1005, '0));
		pending_items.push_back(make_item(FUNC_SNAPSHOT, SIDE_BUY, 32'd1, 48'd2));
		pending_items.push_back(make_item(FUNC_SNAPSHOT, SIDE_BUY, 32'd3, 48'd2));
		for (int i = 0; i < LEVELS + 2; i++) begin
			pending_items.push_back(make_item(FUNC_UPDATE, SIDE_BUY, 32'd1000 + i, '0));
			pending_items.push_back(make_item(FUNC_UPDATE, SIDE_SELL, 32'd2000 + i, '0));
		end

		// random events
		for (int i = 0; i < 1570; i++) begin
			pending_items.push_back(rand_item());
			if (i == 800) price_pool.delete();
		end
		stim_done = 1;
	end

	// driver: drop the item taken at the last rising edge, then offer the next after a gap
	always @(negedge clk) begin
		if (arst_n) begin
			if (took_q) begin
				void'(pending_items.pop_front());
				gap_left = rand_gap();
			end
			if (start && !took_q) begin
				// hold the offered item until it is taken
			end else if (gap_left > 0) begin
				gap_left = gap_left - 1;
				start <= 1'b0;
			end else if (pending_items.size() > 0) begin
				start <= 1'b1;
				cmd <= pending_items[0];
			end else begin
				start <= 1'b0;
			end
		end else begin
			gap_left = 0;
		end
	end

	// monitor: predict on acceptance, check each result strobe
	always @(posedge clk) begin
		plob_out_t exp_q;
		if (arst_n) begin
			took_q <= start && !busy;
			if (start && !busy) begin
				expected_quotes.push_back(book_apply(cmd));
				idle_cycles <= 0;
			end else if (result_valid) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (result_valid) begin
				if (expected_quotes.size() == 0) begin
					$display("%0t: unexpected result %h", $time, result);
					errors++;
				end else begin
					exp_q = expected_quotes.pop_front();
					if (result.bid_top !== exp_q.bid_top)
						$display("%0t: bid_top exp %h got %h", $time, exp_q.bid_top,
							result.bid_top);
					if (result.ask_top !== exp_q.ask_top)
						$display("%0t: ask_top exp %h got %h", $time, exp_q.ask_top,
							result.ask_top);
					if (result.mid_twice !== exp_q.mid_twice)
						$display("%0t: mid_twice exp %h got %h", $time, exp_q.mid_twice,
							result.mid_twice);
					if (result.both_present !== exp_q.both_present)
						$display("%0t: both_present exp %b got %b", $time,
							exp_q.both_present, result.both_present);
					if (result.dropped !== exp_q.dropped)
						$display("%0t: dropped exp %b got %b", $time, exp_q.dropped,
							result.dropped);
					if (result !== exp_q) errors++;
				end
			end
		end else begin
			took_q <= 1'b0;
			idle_cycles <= 0;
		end
	end

	// end of run and watchdog
	initial begin
		wait (arst_n === 1'b1);
		fork
			begin
				wait (stim_done && pending_items.size() == 0 && !start
					&& expected_quotes.size() == 0);
				repeat (DRAIN_CYCLES) @(posedge clk);
			end
			begin
				wait (idle_cycles >= STALL_LIMIT);
				errors++;
			end
		join_any
		if (errors == 0 && expected_quotes.size() == 0)
			$display("price_level_order_book_test: clean");
		else
			$display("price_level_order_book_test: errors");
		$finish;
	end
endmodule
